// ===== rtl/core/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
// No dependencies; used by every module under rtl/core.
package jsu_pkg;

  // Result error codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BAD_ESC  = 3'd1,
    ERR_BAD_HEX  = 3'd2,
    ERR_LONE_LOW = 3'd3,
    ERR_NO_PAIR  = 3'd4,
    ERR_BAD_LOW  = 3'd5,
    ERR_TRUNC    = 3'd6
  } err_code_t;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // Output transaction payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [2:0] error_code;
    logic       out_last;
  } out_t;

  localparam int RES_MAX = 4;                 // most results one input byte can cause
  localparam int RES_IDX_W = $clog2(RES_MAX);

  // One classified input byte: a burst of 1..4 data bytes, or a single
  // marker/error result.
  typedef struct packed {
    logic [RES_MAX-1:0][7:0] bytes;
    logic [RES_IDX_W-1:0]    cnt;     // number of data bytes minus one
    logic                    data;    // 1: data burst, 0: marker or error
    err_code_t               err;
    logic                    last;
  } rec_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

// ===== rtl/core/jsu_front.sv =====
// Front end: accepts raw string bytes, runs the escape state machine and
// emits one record per byte that causes output. Depends on jsu_pkg.
module jsu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,      // byte accepted this cycle
  input  jsu_pkg::in_t    in_data,
  output logic            rec_valid,
  output jsu_pkg::rec_t   rec
);

  typedef enum logic [2:0] {
    M_PLAIN,
    M_ESC,
    M_HEX1,
    M_WANT_BS,
    M_WANT_U,
    M_HEX2
  } mode_t;

  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_U      = 8'h75;
  localparam logic [10:0] PLANE_ADD = 11'd64;  // 0x10000 >> 10

  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  hs_r, hs_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        drop_r, drop_nxt;

  logic [7:0]  b;
  logic        last;
  logic [4:0]  hex_res;
  logic        hex_ok;
  logic [15:0] acc_new;
  logic [8:0]  esc_res;
  logic [10:0] cp_hi;
  logic [20:0] cp;

  // {ok, value}
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [7:0] lo, up;
    lo = c - 8'h57;
    up = c - 8'h37;
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) return {1'b1, lo[3:0]};
    else if (c >= 8'h41 && c <= 8'h46) return {1'b1, up[3:0]};
    else return 5'd0;
  endfunction

  // {ok, byte}
  function automatic logic [8:0] simple_esc(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h5C:   r = {1'b1, 8'h5C};
      8'h22:   r = {1'b1, 8'h22};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h74:   r = {1'b1, 8'h09};
      8'h72:   r = {1'b1, 8'h0D};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  assign b       = in_data.in_byte;
  assign last    = in_data.in_last;
  assign hex_res = hex_of(b);
  assign hex_ok  = hex_res[4];
  assign acc_new = {acc_r[11:0], hex_res[3:0]};
  assign esc_res = simple_esc(b);
  assign cp_hi   = {1'b0, hs_r} + PLANE_ADD;
  assign cp      = {cp_hi[10:0], acc_new[9:0]};

  always_comb begin
    jsu_pkg::err_code_t err;
    err       = jsu_pkg::ERR_NONE;
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    hs_nxt    = hs_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    rec       = '0;
    rec_valid = 1'b0;

    if (drop_r) begin
      // dropping to end of string: only the last byte answers
      if (last) begin
        rec_valid = 1'b1;
        rec.last  = 1'b1;
        mode_nxt  = M_PLAIN;
        acc_nxt   = '0;
        hs_nxt    = '0;
        cnt_nxt   = '0;
        drop_nxt  = 1'b0;
      end
    end else begin
      case (mode_r)
        M_PLAIN: begin
          if (b == CH_BSLASH) begin
            mode_nxt = M_ESC;
          end else begin
            rec_valid    = 1'b1;
            rec.data     = 1'b1;
            rec.bytes[0] = b;
          end
        end
        M_ESC: begin
          if (b == CH_U) begin
            mode_nxt = M_HEX1;
            acc_nxt  = '0;
            cnt_nxt  = '0;
          end else if (esc_res[8]) begin
            rec_valid    = 1'b1;
            rec.data     = 1'b1;
            rec.bytes[0] = esc_res[7:0];
            mode_nxt     = M_PLAIN;
          end else begin
            err = jsu_pkg::ERR_BAD_ESC;
          end
        end
        M_HEX1, M_HEX2: begin
          if (!hex_ok) begin
            err = jsu_pkg::ERR_BAD_HEX;
          end else begin
            acc_nxt = acc_new;
            if (cnt_r != 2'd3) begin
              cnt_nxt = cnt_r + 2'd1;
            end else begin
              cnt_nxt = '0;
              if (mode_r == M_HEX1) begin
                if (acc_new[15:7] == '0) begin
                  rec_valid    = 1'b1;
                  rec.data     = 1'b1;
                  rec.bytes[0] = acc_new[7:0];
                  mode_nxt     = M_PLAIN;
                end else if (acc_new[15:11] == '0) begin
                  rec_valid    = 1'b1;
                  rec.data     = 1'b1;
                  rec.cnt      = 2'd1;
                  rec.bytes[0] = {3'b110, acc_new[10:6]};
                  rec.bytes[1] = {2'b10, acc_new[5:0]};
                  mode_nxt     = M_PLAIN;
                end else if (acc_new[15:11] != 5'b11011) begin
                  rec_valid    = 1'b1;
                  rec.data     = 1'b1;
                  rec.cnt      = 2'd2;
                  rec.bytes[0] = {4'b1110, acc_new[15:12]};
                  rec.bytes[1] = {2'b10, acc_new[11:6]};
                  rec.bytes[2] = {2'b10, acc_new[5:0]};
                  mode_nxt     = M_PLAIN;
                end else if (!acc_new[10]) begin
                  hs_nxt   = acc_new[9:0];
                  mode_nxt = M_WANT_BS;
                end else begin
                  err = jsu_pkg::ERR_LONE_LOW;
                end
              end else begin
                if (acc_new[15:10] == 6'b110111) begin
                  rec_valid    = 1'b1;
                  rec.data     = 1'b1;
                  rec.cnt      = 2'd3;
                  rec.bytes[0] = {5'b11110, cp[20:18]};
                  rec.bytes[1] = {2'b10, cp[17:12]};
                  rec.bytes[2] = {2'b10, cp[11:6]};
                  rec.bytes[3] = {2'b10, cp[5:0]};
                  mode_nxt     = M_PLAIN;
                end else begin
                  err = jsu_pkg::ERR_BAD_LOW;
                end
              end
            end
          end
        end
        M_WANT_BS: begin
          if (b == CH_BSLASH) mode_nxt = M_WANT_U;
          else err = jsu_pkg::ERR_NO_PAIR;
        end
        M_WANT_U: begin
          if (b == CH_U) begin
            mode_nxt = M_HEX2;
            acc_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            err = jsu_pkg::ERR_NO_PAIR;
          end
        end
        default: begin
          mode_nxt     = M_PLAIN;
          rec_valid    = 1'b1;
          rec.data     = 1'b1;
          rec.bytes[0] = b;
        end
      endcase

      if (err != jsu_pkg::ERR_NONE) begin
        rec_valid = 1'b1;
        rec       = '0;
        rec.err   = err;
        rec.last  = last;
        drop_nxt  = !last;
      end else if (last) begin
        if (mode_nxt != M_PLAIN) begin
          rec_valid = 1'b1;
          rec       = '0;
          rec.err   = (mode_nxt == M_WANT_BS) ? jsu_pkg::ERR_NO_PAIR : jsu_pkg::ERR_TRUNC;
          rec.last  = 1'b1;
        end else if (rec_valid) begin
          rec.last = 1'b1;
        end else begin
          rec_valid = 1'b1;
          rec.last  = 1'b1;
        end
      end

      if (last) begin
        mode_nxt = M_PLAIN;
        acc_nxt  = '0;
        hs_nxt   = '0;
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_PLAIN;
      acc_r  <= '0;
      hs_r   <= '0;
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      hs_r   <= hs_nxt;
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // string end always returns the decoder to plain text
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_data.in_last) |=> (mode_r == M_PLAIN && !drop_r && cnt_r == 2'd0))
    else $error("decoder state not cleared after last byte");
  // the last byte of a string always produces a record
  a_last_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_data.in_last) |-> (rec_valid && rec.last))
    else $error("last byte produced no final record");
  // data records never carry an error code
  a_data_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_valid && rec.data) |-> (rec.err == jsu_pkg::ERR_NONE))
    else $error("data record carries an error code");
  // while dropping, inner bytes give nothing
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (drop_r && !in_data.in_last) |-> !rec_valid)
    else $error("record produced while dropping");
`endif

endmodule

// ===== rtl/core/jsu_queue.sv =====
// Short register FIFO of classified records between front and back ends.
// Depends on jsu_pkg.
module jsu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::rec_t push_data,
  input  logic          pop,
  output jsu_pkg::rec_t head,
  output logic          full,
  output logic          empty
);

  jsu_pkg::rec_t                 mem_r [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [jsu_pkg::QCNT_W-1:0]    count_r;
  logic                          do_push, do_pop;

  localparam logic [jsu_pkg::QPTR_W-1:0] PTR_END = jsu_pkg::QPTR_W'(jsu_pkg::QDEPTH - 1);
  localparam logic [jsu_pkg::QCNT_W-1:0] CNT_FULL = jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH);

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_END) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_END) ? '0 : rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/jsu_back.sv =====
// Back end: expands queued records into output transactions, one per cycle
// while out_ready allows, through a registered output stage. Depends on jsu_pkg.
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  jsu_pkg::rec_t head,
  input  logic          q_empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output jsu_pkg::out_t out_data
);

  jsu_pkg::rec_t                  rec_r, src;
  logic [jsu_pkg::RES_IDX_W-1:0]  idx_r, idx;
  logic                           busy_r;
  logic                           out_valid_r;
  jsu_pkg::out_t                  out_data_r, res;
  logic                           load, have;

  assign load = !out_valid_r || out_ready;
  assign have = busy_r || !q_empty;
  assign pop  = load && !busy_r && !q_empty;
  assign src  = busy_r ? rec_r : head;
  assign idx  = busy_r ? idx_r : '0;

  always_comb begin
    res = '0;
    if (src.data) begin
      res.out_byte  = src.bytes[idx];
      res.out_valid = 1'b1;
      res.out_last  = src.last && (idx == src.cnt);
    end else begin
      res.error_code = src.err;
      res.out_last   = src.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= have;
      if (busy_r) begin
        busy_r <= (idx_r != rec_r.cnt);
        idx_r  <= idx_r + 1'b1;
      end else if (!q_empty && head.data && head.cnt != '0) begin
        busy_r <= 1'b1;
        idx_r  <= jsu_pkg::RES_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && have) out_data_r <= res;
    if (pop) rec_r <= head;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/json_string_unescape.sv =====
// A byte's result passes through the record queue and the registered output stage.
// Throughput: one input byte per cycle while the queue has room; each result is its own
// output transaction, so a \u escape giving two to four UTF-8 bytes holds the output side
// longer, and the four-entry record queue absorbs the difference before in_ready drops.
// Reset: synchronous active-low rst_n clears decoder state, queue and output.
module json_string_unescape (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  jsu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output jsu_pkg::out_t out_data
);

  // Structure:
  //   jsu_front  - escape/hex/surrogate state machine, at most one record per byte
  //   jsu_queue  - short record FIFO so front and back stall independently
  //   jsu_back   - serializes a record (1..4 bytes or one marker) to the port

  logic          fire;
  logic          rec_valid;
  jsu_pkg::rec_t rec;
  jsu_pkg::rec_t head;
  logic          q_full, q_empty, q_pop;

  // A byte is taken whenever the queue has room; every byte can produce
  // at most one record, so room for one is enough.
  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .in_data   (in_data),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  jsu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire && rec_valid),
    .push_data (rec),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
